FILE: design/wris_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wris_pkg
// shared types and codes of the weighted random index selector
// ----------------------------------------------------------------------------
package wris_pkg;

    // fixed field widths
    localparam int TOTAL_W = 22;
    localparam int INDEX_W = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_ENTRIES = 2'd1;
    localparam logic [1:0] CFG_TOTAL   = 2'd2;

    // selection modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_CUM   = 2'd1;
    localparam logic [1:0] MODE_MAP   = 2'd2;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // remainder unit result
    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] rem;
    } t_div_res;

endpackage
`default_nettype wire

FILE: design/wris_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wris_div
// bit-serial restoring remainder of the random word by the configured total
// ----------------------------------------------------------------------------
module wris_div
    import wris_pkg::*;
#(
    parameter int RANDOM_BITS = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [RANDOM_BITS-1:0] i_word,
    input  wire logic [TOTAL_W-1:0]     i_total,
    output t_div_res                    o_res
);

    localparam int CNT_W = $clog2(RANDOM_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [RANDOM_BITS-1:0] r_word;
    logic [TOTAL_W-1:0]     r_rem;
    logic [TOTAL_W:0]       w_shift;
    logic [TOTAL_W:0]       w_diff;

    assign w_shift = {r_rem, r_word[RANDOM_BITS-1]};
    assign w_diff  = w_shift - {1'b0, i_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RANDOM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= r_word << 1;
            if (w_shift >= {1'b0, i_total}) begin
                r_rem <= w_diff[TOTAL_W-1:0];
            end else begin
                r_rem <= w_shift[TOTAL_W-1:0];
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

endmodule
`default_nettype wire

FILE: design/weighted_random_index_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_random_index_select
// roulette wheel selection, or a direct lookup in map mode, over a table held in one synchronous memory
// ----------------------------------------------------------------------------
// usage
//   input beats arrive on the s channel; tuser carries the command
//   a load beat writes one table entry and gives no output beat
//   a draw beat reduces random_word modulo weight_total and gives one output
//   beat with chosen_index and range_error on the m channel
//   mode 0 scans plain weights with a running sum, mode 1 scans cumulative
//   weights, mode 2 reads the table at the reduced value directly
// draw sequence
//   a draw runs the bit-serial remainder unit, then issues one memory read
//   per scanned entry (at most one read in map mode); the s channel takes no
//   beat, load or draw, until the result has entered the output register
// reset
//   synchronous active low; mode 0, entries_in_use 0, weight_total 1, no
//   output pending; table contents are undefined until loaded
// stall
//   the output register holds a finished beat while m tready is low; the
//   block keeps taking loads and starts the next draw meanwhile, and waits
//   only before handing over its next result
// ----------------------------------------------------------------------------
module weighted_random_index_select
    import wris_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ENTRY_BITS  = 16,
    parameter int RANDOM_BITS = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration writes
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [21:0]  i_cfg_wdata,
    // input beats
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [55:0]  i_s_tdata,   // slot[5:0], entry_value[21:6], random_word[52:22]
    input  wire logic         i_s_tuser,   // cmd
    // result beats
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [7:0]        o_m_tdata    // chosen_index[6:0], range_error[7]
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW   = $clog2(TABLE_DEPTH + 1);
    localparam int SUMW = ENTRY_BITS + AW;
    localparam int CW   = (SUMW > RANDOM_BITS) ? SUMW : RANDOM_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // table memory
    logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_BITS-1:0] r_rdata;

    // control and configuration
    logic [2:0]             r_state, n_state;
    logic [1:0]             r_mode;
    logic [6:0]             r_entries;
    logic [TOTAL_W-1:0]     r_total;

    // draw datapath
    logic [RANDOM_BITS-1:0] r_word, n_word;
    logic [RANDOM_BITS-1:0] r_r, n_r;
    logic [SUMW-1:0]        r_sum, n_sum;
    logic [NW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_didx, n_didx;
    logic                   r_dv, n_dv;
    logic [INDEX_W-1:0]     r_res_idx, n_res_idx;
    logic                   r_res_err, n_res_err;

    // output register
    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_odata, n_odata;

    // combinational helpers
    logic                   w_accept;
    logic [5:0]             w_slot;
    logic [15:0]            w_value;
    logic [30:0]            w_rword;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic                   w_start;
    logic [RANDOM_BITS-1:0] w_rfin;
    logic [NW-1:0]          w_n;
    logic [SUMW-1:0]        w_sum_nx;
    logic                   w_hit;
    t_div_res               w_div;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_slot   = i_s_tdata[5:0];
    assign w_value  = i_s_tdata[21:6];
    assign w_rword  = i_s_tdata[52:22];
    assign w_waddr  = AW'(w_slot);
    assign w_we     = w_accept && (i_s_tuser == CMD_LOAD) && (32'(w_slot) < TABLE_DEPTH);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // scan count saturates at the table depth
    assign w_n = (32'(r_entries) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(r_entries);

    // zero total leaves the word unreduced
    assign w_rfin = (r_total == '0) ? r_word : RANDOM_BITS'(w_div.rem);

    assign w_sum_nx = r_sum + SUMW'(r_rdata);
    assign w_hit    = (r_mode == MODE_CUM) ? (CW'(r_rdata) > CW'(r_r))
                                           : (CW'(w_sum_nx) > CW'(r_r));

    wris_div #(
        .RANDOM_BITS (RANDOM_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_word  (RANDOM_BITS'(w_rword)),
        .i_total (r_total),
        .o_res   (w_div)
    );

    // table memory, synchronous write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= ENTRY_BITS'(w_value);
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_r       = r_r;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_didx    = r_didx;
        n_dv      = r_dv;
        n_res_idx = r_res_idx;
        n_res_err = r_res_err;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        w_re      = 1'b0;
        w_raddr   = r_cnt[AW-1:0];
        w_start   = 1'b0;

        // downstream took the held beat
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_tuser == CMD_DRAW)) begin
                    n_word  = RANDOM_BITS'(w_rword);
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_r   = w_rfin;
                    n_sum = '0;
                    n_cnt = '0;
                    n_dv  = 1'b0;
                    if (r_mode == MODE_MAP) begin
                        if (w_rfin < RANDOM_BITS'(TABLE_DEPTH)) begin
                            w_re    = 1'b1;
                            w_raddr = w_rfin[AW-1:0];
                            n_state = S_MAP;
                        end else begin
                            n_res_idx = '0;
                            n_res_err = 1'b1;
                            n_state   = S_OUT;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one read issued per cycle, data of the previous read checked
                if (r_dv) begin
                    n_sum = w_sum_nx;
                end
                priority if (r_dv && w_hit) begin
                    n_res_idx = INDEX_W'(r_didx);
                    n_res_err = 1'b0;
                    n_dv      = 1'b0;
                    n_state   = S_OUT;
                end else if (!r_dv && (r_cnt == w_n)) begin
                    n_res_idx = INDEX_W'(w_n);
                    n_res_err = 1'b0;
                    n_state   = S_OUT;
                end else if (r_cnt != w_n) begin
                    w_re    = 1'b1;
                    w_raddr = r_cnt[AW-1:0];
                    n_dv    = 1'b1;
                    n_didx  = r_cnt;
                    n_cnt   = r_cnt + 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
            end
            S_MAP: begin
                n_res_idx = INDEX_W'(r_rdata);
                n_res_err = 1'b0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_res_err, r_res_idx};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_dv      <= 1'b0;
            r_mode    <= MODE_PLAIN;
            r_entries <= '0;
            r_total   <= TOTAL_W'(1);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MODE:    r_mode    <= i_cfg_wdata[1:0];
                    CFG_ENTRIES: r_entries <= i_cfg_wdata[6:0];
                    CFG_TOTAL:   r_total   <= i_cfg_wdata;
                    default:     ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_r       <= n_r;
        r_sum     <= n_sum;
        r_cnt     <= n_cnt;
        r_didx    <= n_didx;
        r_res_idx <= n_res_idx;
        r_res_err <= n_res_err;
        r_odata   <= n_odata;
    end

endmodule
`default_nettype wire

FILE: design/wris_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wris_chk
// port level checks of the weighted random index selector
// ----------------------------------------------------------------------------
module wris_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_s_tuser,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  i_m_tdata
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("result beat changed while stalled");

    // no result pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // a draw occupies the block on the next cycle
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && i_s_tuser) |=> !i_s_tready)
        else $error("draw accepted but input still ready");

    // a load never raises a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && !i_s_tuser && !i_m_tvalid) |=> !i_m_tvalid)
        else $error("result appeared after a load");

    // range error comes with index zero
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[7]) |-> (i_m_tdata[6:0] == 7'd0))
        else $error("range error with nonzero index");

endmodule

bind weighted_random_index_select wris_chk u_wris_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
`default_nettype wire
